// ----- src/hrbe_pkg.sv -----
// Shared types, constants and parsing helpers for the HTTP response body extractor.
// Depends on nothing; every other file of the block imports it.
package hrbe_pkg;

    localparam int HOLD_DEPTH = 31;
    localparam int HOLD_AW    = $clog2(HOLD_DEPTH);
    localparam int HOLD_CW    = $clog2(HOLD_DEPTH + 1);
    localparam int CHUNK_BITS = 32;
    localparam int KEY_LEN    = 17;
    localparam int NEEDLE_LEN = 7;

    // Chunk parser phases.
    localparam logic [3:0] CP_WS   = 4'd0;
    localparam logic [3:0] CP_SIGN = 4'd1;
    localparam logic [3:0] CP_ZERO = 4'd2;
    localparam logic [3:0] CP_X    = 4'd3;
    localparam logic [3:0] CP_DIG  = 4'd4;
    localparam logic [3:0] CP_REST = 4'd5;
    localparam logic [3:0] CP_DATA = 4'd6;
    localparam logic [3:0] CP_DCR  = 4'd7;
    localparam logic [3:0] CP_DLF  = 4'd8;
    localparam logic [3:0] CP_DONE = 4'd9;
    localparam logic [3:0] CP_ERR  = 4'd10;

    // Closing status codes.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_HDR   = 3'd1;
    localparam logic [2:0] ST_NOT_2XX  = 3'd2;
    localparam logic [2:0] ST_BAD_SIZE = 3'd3;
    localparam logic [2:0] ST_TRUNC    = 3'd4;
    localparam logic [2:0] ST_NO_ZERO  = 3'd5;
    localparam logic [2:0] ST_OVERFLOW = 3'd6;

    // Whitespace hold codes.
    localparam logic [1:0] HC_CR = 2'd0;
    localparam logic [1:0] HC_LF = 2'd1;
    localparam logic [1:0] HC_SP = 2'd2;

    typedef struct packed {
        logic [4:0] pos;
        logic [1:0] phase;
        logic [2:0] needle;
        logic       chunked;
    } hdr_t;

    typedef struct packed {
        logic [3:0]            phase;
        logic [CHUNK_BITS-1:0] rem;
        logic [2:0]            err;
    } ck_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic               accept;
        logic               mem_rd;
        logic [HOLD_AW-1:0] rd_addr;
        logic               load_hold;
        logic               load_byte;
        logic               load_close;
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic [HOLD_CW-1:0] flush_cnt;
        logic               emit;
        logic               eor;
        logic               out_free;
    } stat_t;

    function automatic logic [7:0] key_char(input logic [4:0] pos);
        logic [7:0] ch;
        case (pos)
            5'd0: ch = "t";   5'd1: ch = "r";   5'd2: ch = "a";   5'd3: ch = "n";
            5'd4: ch = "s";   5'd5: ch = "f";   5'd6: ch = "e";   5'd7: ch = "r";
            5'd8: ch = "-";   5'd9: ch = "e";   5'd10: ch = "n";  5'd11: ch = "c";
            5'd12: ch = "o";  5'd13: ch = "d";  5'd14: ch = "i";  5'd15: ch = "n";
            5'd16: ch = "g";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] needle_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0: ch = "c"; 3'd1: ch = "h"; 3'd2: ch = "u"; 3'd3: ch = "n";
            3'd4: ch = "k"; 3'd5: ch = "e"; 3'd6: ch = "d";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    // Hex digit value, or 16 for a non-digit.
    function automatic logic [4:0] hexval(input logic [7:0] c);
        logic [4:0] d;
        if (c >= "0" && c <= "9")      d = 5'(c - "0");
        else if (c >= "a" && c <= "f") d = 5'(c - "a" + 8'd10);
        else if (c >= "A" && c <= "F") d = 5'(c - "A" + 8'd10);
        else                           d = 5'd16;
        return d;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    // One content byte of a header line.
    function automatic hdr_t hdr_content(input hdr_t s, input logic [7:0] c);
        hdr_t r;
        r = s;
        if (s.phase == 2'd0) begin
            if (s.pos < 5'(KEY_LEN)) begin
                if (to_lower(c) == key_char(s.pos)) r.pos = s.pos + 5'd1;
                else r.phase = 2'd2;
            end else begin
                r.phase = (c == ":") ? 2'd1 : 2'd2;
            end
        end else if (s.phase == 2'd1) begin
            if (c == needle_char(s.needle)) r.needle = s.needle + 3'd1;
            else r.needle = (c == "c") ? 3'd1 : 3'd0;
            if (r.needle >= 3'(NEEDLE_LEN)) begin
                r.chunked = 1'b1;
                r.phase   = 2'd3;
                r.needle  = 3'd0;
            end
        end
        return r;
    endfunction

    function automatic ck_t ck_fail(input ck_t s, input logic [2:0] code);
        ck_t r;
        r = s;
        if (s.err == ST_OK) r.err = code;
        r.phase = CP_ERR;
        return r;
    endfunction

    // Shift one hex digit into the size, saturating at all ones.
    function automatic logic [CHUNK_BITS-1:0] accumulate(input logic [CHUNK_BITS-1:0] v,
                                                         input logic [4:0] d);
        logic [CHUNK_BITS-1:0] r;
        if (v[CHUNK_BITS-1 -: 4] != 4'd0) r = '1;
        else r = {v[CHUNK_BITS-5:0], d[3:0]};
        return r;
    endfunction

    // One content byte of a chunk size line.
    function automatic ck_t size_content(input ck_t s, input logic [7:0] c);
        ck_t        r;
        logic [4:0] d;
        logic       sign_step;
        r = s;
        d = hexval(c);
        sign_step = 1'b0;
        case (s.phase)
            CP_WS: begin
                if (!is_space(c)) begin
                    if (c == "+") r.phase = CP_SIGN;
                    else sign_step = 1'b1;
                end
            end
            CP_SIGN: sign_step = 1'b1;
            CP_ZERO: begin
                if (c == "x" || c == "X") r.phase = CP_X;
                else if (d < 5'd16) begin
                    r.rem   = accumulate(s.rem, d);
                    r.phase = CP_DIG;
                end else r.phase = CP_REST;
            end
            CP_X, CP_DIG: begin
                if (d < 5'd16) begin
                    r.rem   = accumulate(s.rem, d);
                    r.phase = CP_DIG;
                end else r.phase = CP_REST;
            end
            default: ;
        endcase
        if (sign_step) begin
            if (d == 5'd0) begin
                r.rem   = '0;
                r.phase = CP_ZERO;
            end else if (d < 5'd16) begin
                r.rem   = CHUNK_BITS'(d);
                r.phase = CP_DIG;
            end else begin
                r = ck_fail(s, ST_BAD_SIZE);
            end
        end
        return r;
    endfunction

    function automatic ck_t size_line_end(input ck_t s);
        ck_t r;
        r = s;
        if (s.phase == CP_WS || s.phase == CP_SIGN) r = ck_fail(s, ST_BAD_SIZE);
        else if (s.phase <= CP_REST) r.phase = (s.rem == '0) ? CP_DONE : CP_DATA;
        return r;
    endfunction

    function automatic logic [7:0] hold_char(input logic [1:0] code);
        logic [7:0] ch;
        case (code)
            HC_LF:   ch = 8'd10;
            HC_SP:   ch = 8'd32;
            default: ch = 8'd13;
        endcase
        return ch;
    endfunction

endpackage

// ----- src/hrbe_ctrl.sv -----
// Sequencing controller of the body extractor: input handshake, hold flush, result order.
// Depends on hrbe_pkg.
module hrbe_ctrl
    import hrbe_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_RD    = 5'b00010,
        S_FL    = 5'b00100,
        S_BYTE  = 5'b01000,
        S_CLOSE = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [HOLD_CW-1:0] idx_reg, idx_next;
    logic [HOLD_CW-1:0] cnt_reg, cnt_next;
    logic               eor_reg, eor_next;
    logic               accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    // Next state and commands.
    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        eor_next       = eor_reg;
        cmd            = '0;
        cmd.accept     = accept;
        cmd.rd_addr    = idx_reg[HOLD_AW-1:0];
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    idx_next = '0;
                    cnt_next = stat.flush_cnt;
                    eor_next = stat.eor;
                    if (stat.emit && stat.flush_cnt != '0) state_next = S_RD;
                    else if (stat.emit) state_next = S_BYTE;
                    else if (stat.eor) state_next = S_CLOSE;
                end
            end
            S_RD: begin
                cmd.mem_rd = 1'b1;
                state_next = S_FL;
            end
            S_FL: begin
                if (stat.out_free) begin
                    cmd.load_hold = 1'b1;
                    idx_next      = idx_reg + 1'b1;
                    state_next    = (idx_reg + 1'b1 == cnt_reg) ? S_BYTE : S_RD;
                end
            end
            S_BYTE: begin
                if (stat.out_free) begin
                    cmd.load_byte = 1'b1;
                    state_next    = eor_reg ? S_CLOSE : S_IDLE;
                end
            end
            S_CLOSE: begin
                if (stat.out_free) begin
                    cmd.load_close = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            cnt_reg   <= '0;
            eor_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
            eor_reg   <= eor_next;
        end
    end

endmodule

// ----- src/hrbe_dp.sv -----
// Parsing datapath of the body extractor: header and chunk state, hold memory, output beat.
// Depends on hrbe_pkg.
module hrbe_dp
    import hrbe_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] s_byte_in,
    input  logic       s_end_of_response,
    input  cmd_t       cmd,
    output stat_t      stat,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_body_byte,
    output logic       m_has_byte,
    output logic       m_last,
    output logic [2:0] m_status
);

    logic [1:0]         blank_reg, blank_next;
    logic               in_body_reg, in_body_next;
    logic [1:0]         sphase_reg, sphase_next;
    logic [8:0]         sval_reg, sval_next;
    logic               sbad_reg, sbad_next;
    hdr_t               hdr_reg, hdr_next;
    logic               cp_reg, cp_next;
    ck_t                ck_reg, ck_next;
    logic [HOLD_CW-1:0] hcnt_reg, hcnt_next;
    logic               hold_we;
    logic [1:0]         hold_wcode;
    logic               emit;
    logic [HOLD_CW-1:0] flush_cnt;
    logic [11:0]        sval_wide;
    logic [7:0]         c;

    logic [1:0]         hold_mem [HOLD_DEPTH];
    logic [1:0]         hold_rdata_reg;
    logic [7:0]         byte_reg;
    logic               valid_reg;
    logic [7:0]         obyte_reg;
    logic               ohas_reg, olast_reg;
    logic [2:0]         ostat_reg;
    logic [2:0]         close_status;
    logic               out_free;

    assign c        = s_byte_in;
    assign out_free = !valid_reg || m_ready;

    // Per-beat parse: every next value assumes the input beat is accepted.
    always_comb begin
        blank_next   = blank_reg;
        in_body_next = in_body_reg;
        sphase_next  = sphase_reg;
        sval_next    = sval_reg;
        sbad_next    = sbad_reg;
        hdr_next     = hdr_reg;
        cp_next      = cp_reg;
        ck_next      = ck_reg;
        hcnt_next    = hcnt_reg;
        hold_we      = 1'b0;
        hold_wcode   = HC_CR;
        emit         = 1'b0;
        flush_cnt    = '0;
        sval_wide    = 12'(sval_reg) * 12'd10 + 12'(c - "0");

        // Status code between the first two spaces.
        if (sphase_reg == 2'd0) begin
            if (c == 8'd32) sphase_next = 2'd1;
        end else if (sphase_reg == 2'd1) begin
            if (c == 8'd32) sphase_next = 2'd2;
            else if (c >= "0" && c <= "9") begin
                sval_next = (sval_wide > 12'd300) ? 9'd300 : sval_wide[8:0];
            end else sbad_next = 1'b1;
        end

        if (!in_body_reg) begin
            // Header lines, with a pending CR resolved against the next byte.
            if (cp_reg) begin
                if (c == 8'd10) begin
                    cp_next         = 1'b0;
                    hdr_next.pos    = '0;
                    hdr_next.phase  = '0;
                    hdr_next.needle = '0;
                end else begin
                    hdr_next = hdr_content(hdr_reg, 8'd13);
                    if (c != 8'd13) begin
                        cp_next  = 1'b0;
                        hdr_next = hdr_content(hdr_next, c);
                    end
                end
            end else if (c == 8'd13) begin
                cp_next = 1'b1;
            end else begin
                hdr_next = hdr_content(hdr_reg, c);
            end
            // Blank line detection.
            if (c == 8'd13) blank_next = (blank_reg == 2'd2) ? 2'd3 : 2'd1;
            else if (c == 8'd10) begin
                if (blank_reg == 2'd3) begin
                    in_body_next = 1'b1;
                    cp_next      = 1'b0;
                    blank_next   = 2'd0;
                end else blank_next = (blank_reg == 2'd1) ? 2'd2 : 2'd0;
            end else blank_next = 2'd0;
        end else if (hdr_reg.chunked) begin
            // Chunked body.
            case (ck_reg.phase)
                CP_DATA: begin
                    emit        = 1'b1;
                    ck_next.rem = ck_reg.rem - 1'b1;
                    if (ck_next.rem == '0) ck_next.phase = CP_DCR;
                end
                CP_DCR: begin
                    if (c == 8'd13) ck_next.phase = CP_DLF;
                    else ck_next = ck_fail(ck_reg, ST_TRUNC);
                end
                CP_DLF: begin
                    if (c == 8'd10) begin
                        ck_next.phase = CP_WS;
                        ck_next.rem   = '0;
                    end else ck_next = ck_fail(ck_reg, ST_TRUNC);
                end
                CP_DONE, CP_ERR: ;
                default: begin
                    if (cp_reg) begin
                        if (c == 8'd10) begin
                            cp_next = 1'b0;
                            ck_next = size_line_end(ck_reg);
                        end else begin
                            ck_next = size_content(ck_reg, 8'd13);
                            if (ck_next.phase > CP_REST) cp_next = 1'b0;
                            else if (c != 8'd13) begin
                                cp_next = 1'b0;
                                ck_next = size_content(ck_next, c);
                            end
                        end
                    end else if (c == 8'd13) begin
                        cp_next = 1'b1;
                    end else begin
                        ck_next = size_content(ck_reg, c);
                    end
                end
            endcase
        end else if (ck_reg.err == ST_OK) begin
            // Plain body: whitespace is held until a later visible byte.
            if (c == 8'd13 || c == 8'd10 || c == 8'd32) begin
                if (hcnt_reg >= HOLD_CW'(HOLD_DEPTH)) begin
                    ck_next = ck_fail(ck_reg, ST_OVERFLOW);
                end else begin
                    hold_we    = 1'b1;
                    hold_wcode = (c == 8'd13) ? HC_CR : (c == 8'd10) ? HC_LF : HC_SP;
                    hcnt_next  = hcnt_reg + 1'b1;
                end
            end else begin
                emit      = 1'b1;
                flush_cnt = hcnt_reg;
                hcnt_next = '0;
            end
        end
    end

    // Closing status, priority as the header and body checks demand.
    always_comb begin
        if (!in_body_reg) close_status = ST_NO_HDR;
        else if (sphase_reg != 2'd2 || sbad_reg || sval_reg < 9'd200 || sval_reg >= 9'd300)
            close_status = ST_NOT_2XX;
        else if (ck_reg.err != ST_OK) close_status = ck_reg.err;
        else if (!hdr_reg.chunked || ck_reg.phase == CP_DONE) close_status = ST_OK;
        else if (ck_reg.phase == CP_DATA || ck_reg.phase == CP_DCR || ck_reg.phase == CP_DLF)
            close_status = ST_TRUNC;
        else close_status = ST_NO_ZERO;
    end

    assign stat.flush_cnt = flush_cnt;
    assign stat.emit      = emit;
    assign stat.eor       = s_end_of_response;
    assign stat.out_free  = out_free;

    // Parser state; the closing beat returns everything to reset.
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.load_close) begin
            blank_reg   <= '0;
            in_body_reg <= 1'b0;
            sphase_reg  <= '0;
            sval_reg    <= '0;
            sbad_reg    <= 1'b0;
            hdr_reg     <= '0;
            cp_reg      <= 1'b0;
            ck_reg      <= '{phase: CP_WS, rem: '0, err: ST_OK};
            hcnt_reg    <= '0;
        end else if (cmd.accept) begin
            blank_reg   <= blank_next;
            in_body_reg <= in_body_next;
            sphase_reg  <= sphase_next;
            sval_reg    <= sval_next;
            sbad_reg    <= sbad_next;
            hdr_reg     <= hdr_next;
            cp_reg      <= cp_next;
            ck_reg      <= ck_next;
            hcnt_reg    <= hcnt_next;
        end
    end

    // Hold memory and the byte that waits behind the flush.
    always_ff @(posedge aclk) begin
        if (cmd.accept && hold_we) hold_mem[hcnt_reg[HOLD_AW-1:0]] <= hold_wcode;
        if (cmd.mem_rd) hold_rdata_reg <= hold_mem[cmd.rd_addr];
        if (cmd.accept) byte_reg <= c;
    end

    // Output beat register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.load_hold || cmd.load_byte || cmd.load_close) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_hold) begin
            obyte_reg <= hold_char(hold_rdata_reg);
            ohas_reg  <= 1'b1;
            olast_reg <= 1'b0;
            ostat_reg <= ST_OK;
        end else if (cmd.load_byte) begin
            obyte_reg <= byte_reg;
            ohas_reg  <= 1'b1;
            olast_reg <= 1'b0;
            ostat_reg <= ST_OK;
        end else if (cmd.load_close) begin
            obyte_reg <= 8'd0;
            ohas_reg  <= 1'b0;
            olast_reg <= 1'b1;
            ostat_reg <= close_status;
        end
    end

    assign m_valid     = valid_reg;
    assign m_body_byte = obyte_reg;
    assign m_has_byte  = ohas_reg;
    assign m_last      = olast_reg;
    assign m_status    = ostat_reg;

endmodule

// ----- src/http_response_body_extractor.sv -----
// Top level of the HTTP response body extractor.
// Depends on hrbe_pkg, hrbe_ctrl and hrbe_dp.
//
// Takes a response one byte per beat and returns its body bytes, decoding chunked
// transfer encoding, followed by one closing beat with last set and a status code.
// A byte that yields no result is only accepted; a byte that yields one body beat
// is accepted and then loaded into the output register; a visible byte in a plain
// body that releases N held CR, LF or space bytes first reads the hold memory and
// loads the output register once per held byte, then loads its own byte; a final
// byte adds the closing beat. Each load of the output register waits while the
// beat before it is still held there by a low m_ready. A new byte is taken while a
// finished beat still waits on the output register.
module http_response_body_extractor
    import hrbe_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_byte_in,
    input  logic       s_end_of_response,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_body_byte,
    output logic       m_has_byte,
    output logic       m_last,
    output logic [2:0] m_status
);

    cmd_t  cmd;
    stat_t stat;

    hrbe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    hrbe_dp u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_byte_in         (s_byte_in),
        .s_end_of_response (s_end_of_response),
        .cmd               (cmd),
        .stat              (stat),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_body_byte       (m_body_byte),
        .m_has_byte        (m_has_byte),
        .m_last            (m_last),
        .m_status          (m_status)
    );

endmodule
